[rtl/core/srl_pkg.sv]
`timescale 1ns / 1ps

package srl_pkg;

    // Configuration register widths and reset values
    localparam int STEP_W       = 20;
    localparam int MAXOUT_W     = 7;
    localparam int CFG_IDX_W    = 2;
    localparam int CFG_DATA_W   = STEP_W;
    localparam int MAX_RESULTS  = 64;

    localparam logic [STEP_W-1:0]   STEP_RESET   = 20'd65536;
    localparam logic [MAXOUT_W-1:0] MAXOUT_RESET = 7'd64;
    localparam logic [MAXOUT_W-1:0] MAXOUT_CAP   = 7'd64;

    // Register indexes on the configuration port
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_PHASE_STEP  = 2'd0,
        CFG_MAX_OUTPUTS = 2'd1
    } t_cfg_idx;

    // Control from the sequencer to the output stage
    typedef struct packed {
        logic load;
        logic last;
    } t_merge_ctl;

endpackage

[rtl/core/srl_in_if.sv]
`timescale 1ns / 1ps

interface srl_in_if #(
    parameter int SAMPLE_BITS = 16
);
    logic                          valid;
    logic                          ready;
    logic signed [SAMPLE_BITS-1:0] left_in;
    logic signed [SAMPLE_BITS-1:0] right_in;

    modport source (output valid, output left_in, output right_in, input ready);
    modport sink   (input valid, input left_in, input right_in, output ready);
endinterface

[rtl/core/srl_out_if.sv]
`timescale 1ns / 1ps

interface srl_out_if #(
    parameter int SAMPLE_BITS = 16
);
    logic                          valid;
    logic                          ready;
    logic signed [SAMPLE_BITS-1:0] left_out;
    logic signed [SAMPLE_BITS-1:0] right_out;
    logic                          run_last;

    modport source (output valid, output left_out, output right_out, output run_last,
                    input ready);
    modport sink   (input valid, input left_out, input right_out, input run_last,
                    output ready);
endinterface

[rtl/core/stereo_linear_resampler_core.sv]
`timescale 1ns / 1ps

// Stereo linear-interpolation resampler.
// Input channel i_in carries one signed stereo pair per word; output channel
// o_out carries interpolated pairs, run_last marking the final pair made for
// an input word. An input word may give zero pairs (phase at or above one, or max outputs zero).
// Configuration: write i_cfg_data to register i_cfg_idx when i_cfg_we is high
// (0 = phase step, 1 = max outputs per input), only while the block is idle.
// Timing: one input word at a time. After accept, the sequencer checks the run,
// the lane multipliers register the product, and the add result is loaded into
// the output register; each further pair repeats the check, multiply and add
// steps. The next word is accepted once the last pair has been loaded into the
// output register, or after the check step when the word gives no pair.
// Reset (synchronous, active low) clears the held pair and phase to zero and
// restores phase step 1.0 and max outputs 64.
// A stalled receiver holds the output word; the sequencer waits in its add
// step until the output register frees up.
module stereo_linear_resampler_core #(
    parameter int FRAC_BITS   = 16,
    parameter int SAMPLE_BITS = 16
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    srl_in_if.sink                             i_in,
    srl_out_if.source                          o_out,
    input  logic                               i_cfg_we,
    input  logic [srl_pkg::CFG_IDX_W-1:0]      i_cfg_idx,
    input  logic [srl_pkg::CFG_DATA_W-1:0]     i_cfg_data
);
    localparam int PHASE_W = ((FRAC_BITS > srl_pkg::STEP_W) ? FRAC_BITS : srl_pkg::STEP_W) + 1;
    localparam logic [PHASE_W-1:0] PHASE_ONE = PHASE_W'(1) << FRAC_BITS;
    localparam logic [PHASE_W-1:0] PHASE_MAX = PHASE_ONE + (PHASE_W'(1) << srl_pkg::STEP_W);

    typedef enum logic [1:0] {
        S_IDLE,
        S_CHECK,
        S_ADD
    } t_state;

    t_state                                r_state, n_state;
    logic [srl_pkg::STEP_W-1:0]            r_step;
    logic [srl_pkg::MAXOUT_W-1:0]          r_max;
    logic [PHASE_W-1:0]                    r_phase, n_phase;
    logic [srl_pkg::MAXOUT_W-1:0]          r_count, n_count;
    logic                                  r_last, n_last;
    logic signed [SAMPLE_BITS-1:0]         r_held_l, n_held_l;
    logic signed [SAMPLE_BITS-1:0]         r_held_r, n_held_r;
    logic signed [SAMPLE_BITS-1:0]         r_cur_l, n_cur_l;
    logic signed [SAMPLE_BITS-1:0]         r_cur_r, n_cur_r;

    logic                                  phase_lt_one;
    logic [srl_pkg::MAXOUT_W-1:0]          limit;
    logic                                  more;
    logic [PHASE_W-1:0]                    phase_sum;
    logic [PHASE_W-1:0]                    fin_phase;
    logic [srl_pkg::MAXOUT_W-1:0]          cnt_inc;
    logic                                  mul_en;
    logic                                  out_free;
    srl_pkg::t_merge_ctl                   merge_ctl;
    logic signed [SAMPLE_BITS-1:0]         lane_l, lane_r;

    // Run bookkeeping
    assign phase_lt_one = r_phase < PHASE_ONE;
    assign limit        = (r_max > srl_pkg::MAXOUT_CAP) ? srl_pkg::MAXOUT_CAP : r_max;
    assign more         = phase_lt_one && (r_count < limit);
    assign phase_sum    = r_phase + PHASE_W'(r_step);
    assign fin_phase    = phase_lt_one ? r_phase : r_phase - PHASE_ONE;
    assign cnt_inc      = r_count + srl_pkg::MAXOUT_W'(1);

    assign i_in.ready = (r_state == S_IDLE);

    // Sequencer: issue one pair to the lanes, then hand the sum to the output stage
    always_comb begin
        n_state        = r_state;
        n_phase        = r_phase;
        n_count        = r_count;
        n_last         = r_last;
        n_held_l       = r_held_l;
        n_held_r       = r_held_r;
        n_cur_l        = r_cur_l;
        n_cur_r        = r_cur_r;
        mul_en         = 1'b0;
        merge_ctl.load = 1'b0;
        merge_ctl.last = r_last;
        unique case (r_state)
            S_IDLE: begin
                if (i_in.valid) begin
                    n_cur_l = i_in.left_in;
                    n_cur_r = i_in.right_in;
                    n_count = '0;
                    n_state = S_CHECK;
                end
            end
            S_CHECK: begin
                if (more) begin
                    mul_en  = 1'b1;
                    n_phase = phase_sum;
                    n_count = cnt_inc;
                    n_last  = (phase_sum >= PHASE_ONE) || (cnt_inc >= limit);
                    n_state = S_ADD;
                end else begin
                    n_phase  = fin_phase;
                    n_held_l = r_cur_l;
                    n_held_r = r_cur_r;
                    n_state  = S_IDLE;
                end
            end
            S_ADD: begin
                if (out_free) begin
                    merge_ctl.load = 1'b1;
                    if (r_last) begin
                        n_phase  = fin_phase;
                        n_held_l = r_cur_l;
                        n_held_r = r_cur_r;
                        n_state  = S_IDLE;
                    end else begin
                        n_state = S_CHECK;
                    end
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // Hold state, run registers and configuration
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_phase  <= '0;
            r_count  <= '0;
            r_last   <= 1'b0;
            r_held_l <= '0;
            r_held_r <= '0;
            r_step   <= srl_pkg::STEP_RESET;
            r_max    <= srl_pkg::MAXOUT_RESET;
        end else begin
            r_state  <= n_state;
            r_phase  <= n_phase;
            r_count  <= n_count;
            r_last   <= n_last;
            r_held_l <= n_held_l;
            r_held_r <= n_held_r;
            if (i_cfg_we) begin
                unique case (srl_pkg::t_cfg_idx'(i_cfg_idx))
                    srl_pkg::CFG_PHASE_STEP:  r_step <= i_cfg_data;
                    srl_pkg::CFG_MAX_OUTPUTS: r_max  <= i_cfg_data[srl_pkg::MAXOUT_W-1:0];
                    default: ;
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_cur_l <= n_cur_l;
        r_cur_r <= n_cur_r;
    end

    // One lane per channel
    srl_lane #(
        .SAMPLE_BITS (SAMPLE_BITS),
        .FRAC_BITS   (FRAC_BITS)
    ) u_lane_l (
        .i_clk    (i_clk),
        .i_mul_en (mul_en),
        .i_held   (r_held_l),
        .i_cur    (r_cur_l),
        .i_frac   (r_phase[FRAC_BITS-1:0]),
        .o_sample (lane_l)
    );

    srl_lane #(
        .SAMPLE_BITS (SAMPLE_BITS),
        .FRAC_BITS   (FRAC_BITS)
    ) u_lane_r (
        .i_clk    (i_clk),
        .i_mul_en (mul_en),
        .i_held   (r_held_r),
        .i_cur    (r_cur_r),
        .i_frac   (r_phase[FRAC_BITS-1:0]),
        .o_sample (lane_r)
    );

    srl_merge #(
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_merge (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (merge_ctl),
        .i_left  (lane_l),
        .i_right (lane_r),
        .o_free  (out_free),
        .o_out   (o_out)
    );

    a_phase_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_phase < PHASE_MAX)
        else $error("phase accumulator out of range");

    a_count_cap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= srl_pkg::MAXOUT_CAP)
        else $error("run produced too many pairs");

    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_ADD && !out_free) |=> (r_state == S_ADD && $stable(r_phase)))
        else $error("sequencer moved on while output stage was full");

endmodule

[rtl/core/srl_lane.sv]
`timescale 1ns / 1ps

module srl_lane #(
    parameter int SAMPLE_BITS = 16,
    parameter int FRAC_BITS   = 16
) (
    input  logic                          i_clk,
    input  logic                          i_mul_en,
    input  logic signed [SAMPLE_BITS-1:0] i_held,
    input  logic signed [SAMPLE_BITS-1:0] i_cur,
    input  logic        [FRAC_BITS-1:0]   i_frac,
    output logic signed [SAMPLE_BITS-1:0] o_sample
);
    localparam int DIFF_W = SAMPLE_BITS + 1;
    localparam int PROD_W = SAMPLE_BITS + FRAC_BITS + 2;
    localparam int SUM_W  = SAMPLE_BITS + 2;

    logic signed [DIFF_W-1:0]    diff;
    logic signed [FRAC_BITS:0]   frac_s;
    logic signed [PROD_W-1:0]    n_prod;
    logic signed [PROD_W-1:0]    r_prod;
    logic signed [SUM_W-1:0]     shifted;
    logic signed [SUM_W-1:0]     held_x;
    logic signed [SUM_W-1:0]     sum;

    // Difference and full-width product, registered before the add
    assign diff   = {i_cur[SAMPLE_BITS-1], i_cur} - {i_held[SAMPLE_BITS-1], i_held};
    assign frac_s = {1'b0, i_frac};
    assign n_prod = diff * frac_s;

    always_ff @(posedge i_clk) begin
        if (i_mul_en) begin
            r_prod <= n_prod;
        end
    end

    // Floor shift is the arithmetic shift; interpolated value fits the sample width
    assign shifted  = r_prod[PROD_W-1:FRAC_BITS];
    assign held_x   = {{2{i_held[SAMPLE_BITS-1]}}, i_held};
    assign sum      = held_x + shifted;
    assign o_sample = sum[SAMPLE_BITS-1:0];

endmodule

[rtl/core/srl_merge.sv]
`timescale 1ns / 1ps

module srl_merge #(
    parameter int SAMPLE_BITS = 16
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  srl_pkg::t_merge_ctl           i_ctl,
    input  logic signed [SAMPLE_BITS-1:0] i_left,
    input  logic signed [SAMPLE_BITS-1:0] i_right,
    output logic                          o_free,
    srl_out_if.source                     o_out
);
    logic                          r_valid;
    logic signed [SAMPLE_BITS-1:0] r_left;
    logic signed [SAMPLE_BITS-1:0] r_right;
    logic                          r_last;

    // Register is free when empty or drained this cycle
    assign o_free = !r_valid || o_out.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_ctl.load) begin
            r_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_valid <= 1'b0;
        end
    end

    // Join both lanes into one output word
    always_ff @(posedge i_clk) begin
        if (i_ctl.load) begin
            r_left  <= i_left;
            r_right <= i_right;
            r_last  <= i_ctl.last;
        end
    end

    assign o_out.valid     = r_valid;
    assign o_out.left_out  = r_left;
    assign o_out.right_out = r_right;
    assign o_out.run_last  = r_last;

    a_load_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_ctl.load |-> (!r_valid || o_out.ready))
        else $error("output word overwritten before it was taken");

endmodule
